// ===== sv/rbfw_pkg.sv =====
// Shared constants, register indexes and types of the rectangle boundary weight block.
package rbfw_pkg;

  localparam int RBFW_COORD_WIDTH      = 32;
  localparam int RBFW_WEIGHT_FRAC_BITS = 16;
  localparam int RBFW_QUEUE_DEPTH      = 8;
  localparam int RBFW_CFG_INDEX_W      = 3;
  localparam int RBFW_CFG_DATA_W       = 32;

  localparam logic [RBFW_CFG_INDEX_W-1:0] REG_CORNER_A_X       = 3'd0;
  localparam logic [RBFW_CFG_INDEX_W-1:0] REG_CORNER_A_Z       = 3'd1;
  localparam logic [RBFW_CFG_INDEX_W-1:0] REG_CORNER_B_X       = 3'd2;
  localparam logic [RBFW_CFG_INDEX_W-1:0] REG_CORNER_B_Z       = 3'd3;
  localparam logic [RBFW_CFG_INDEX_W-1:0] REG_FEATHER_FRACTION = 3'd4;

  typedef struct packed {
    logic in_rect;
    logic full;
  } rbfw_flags_t;

endpackage

// ===== sv/rbfw_if.sv =====
// Handshake interfaces for the point, result and configuration channels.
interface rbfw_point_if import rbfw_pkg::*; #(
  parameter int COORD_WIDTH = RBFW_COORD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  point_x;
  logic signed [COORD_WIDTH-1:0]  point_z;

  modport source (output valid, output point_x, output point_z, input ready);
  modport sink (input valid, input point_x, input point_z, output ready);
endinterface

interface rbfw_result_if import rbfw_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = RBFW_WEIGHT_FRAC_BITS
);
  logic                        valid;
  logic                        ready;
  logic [WEIGHT_FRAC_BITS:0]   weight;
  logic                        inside_res;

  modport source (output valid, output weight, output inside_res, input ready);
  modport sink (input valid, input weight, input inside_res, output ready);
endinterface

interface rbfw_cfg_if import rbfw_pkg::*; #(
  parameter int DATA_W = RBFW_CFG_DATA_W
);
  logic                         valid;
  logic                         ready;
  logic [RBFW_CFG_INDEX_W-1:0]  index;
  logic [DATA_W-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rect_boundary_feather_weight_top.sv =====
// Top level of the rectangle boundary feather weight block.
//
//   channel  role    payload                         transaction when
//   point    sink    point_x, point_z                valid && ready
//   result   source  weight, inside_res              valid && ready
//   cfg      sink    index, data                     valid && ready (always ready)
//
// One point is taken per cycle while point.ready is high; each gives one result, after the
// front pipeline, the queue and the one-bit-per-stage divider in the back end.
// Reset is synchronous and active high; it clears the corners and fraction to zero.
// A stalled result register holds the divider; the front pipeline keeps running into
// the queue and lowers point.ready once the queue's credits are used up.
module rect_boundary_feather_weight_top import rbfw_pkg::*; #(
  parameter int COORD_WIDTH      = RBFW_COORD_WIDTH,
  parameter int WEIGHT_FRAC_BITS = RBFW_WEIGHT_FRAC_BITS,
  parameter int QUEUE_DEPTH      = RBFW_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  rbfw_point_if.sink      point,
  rbfw_result_if.source   result,
  rbfw_cfg_if.sink        cfg
);

  logic                    push, pop, empty;
  rbfw_flags_t             push_flags, rd_flags;
  logic [COORD_WIDTH-1:0]  push_mind, push_feather, rd_mind, rd_feather;

  rbfw_front #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .QUEUE_DEPTH      (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .point        (point),
    .cfg          (cfg),
    .pop          (pop),
    .push         (push),
    .push_flags   (push_flags),
    .push_mind    (push_mind),
    .push_feather (push_feather)
  );

  rbfw_queue #(
    .COORD_WIDTH (COORD_WIDTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_flags   (push_flags),
    .push_mind    (push_mind),
    .push_feather (push_feather),
    .pop          (pop),
    .empty        (empty),
    .rd_flags     (rd_flags),
    .rd_mind      (rd_mind),
    .rd_feather   (rd_feather)
  );

  rbfw_back #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .rd_flags   (rd_flags),
    .rd_mind    (rd_mind),
    .rd_feather (rd_feather),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== sv/rbfw_front.sv =====
// Front end: configuration registers, point classification and feather length pipeline.
module rbfw_front import rbfw_pkg::*; #(
  parameter int COORD_WIDTH      = RBFW_COORD_WIDTH,
  parameter int WEIGHT_FRAC_BITS = RBFW_WEIGHT_FRAC_BITS,
  parameter int QUEUE_DEPTH      = RBFW_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  rbfw_point_if.sink              point,
  rbfw_cfg_if.sink                cfg,
  input  logic                    pop,
  output logic                    push,
  output rbfw_flags_t             push_flags,
  output logic [COORD_WIDTH-1:0]  push_mind,
  output logic [COORD_WIDTH-1:0]  push_feather
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int FW    = WEIGHT_FRAC_BITS + 1;
  localparam int PW    = DW + FW;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(1 << WEIGHT_FRAC_BITS);

  logic signed [CW-1:0] corner_a_x, corner_a_z, corner_b_x, corner_b_z;
  logic [FW-1:0]        feather_fraction;
  logic [CNT_W-1:0]     credit;
  logic                 accept;

  // Stage 1: ordered corners and the query point.
  logic                 s1_valid;
  logic signed [CW-1:0] s1_px, s1_pz, s1_x_lo, s1_x_hi, s1_z_lo, s1_z_hi;
  logic [FW-1:0]        s1_frac;
  logic                 a_lt_b_x, a_lt_b_z;
  logic [FW-1:0]        frac_sat;

  // Stage 2: edge distances and sides.
  logic                 s2_valid, s2_inside;
  logic [DW-1:0]        s2_d0, s2_d1, s2_d2, s2_d3, s2_sx, s2_sz;
  logic [FW-1:0]        s2_frac;

  // Stage 3: shorter side and partial minima.
  logic                 s3_valid, s3_inside;
  logic [DW-1:0]        s3_side, s3_m01, s3_m23;
  logic [FW-1:0]        s3_frac;

  // Stage 4: feather product and smallest distance.
  logic                 s4_valid, s4_inside;
  logic [PW-1:0]        s4_prod;
  logic [DW-1:0]        s4_mind;
  logic [DW-1:0]        feather;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_a_x       <= '0;
      corner_a_z       <= '0;
      corner_b_x       <= '0;
      corner_b_z       <= '0;
      feather_fraction <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CORNER_A_X:       corner_a_x       <= cfg.data[CW-1:0];
        REG_CORNER_A_Z:       corner_a_z       <= cfg.data[CW-1:0];
        REG_CORNER_B_X:       corner_b_x       <= cfg.data[CW-1:0];
        REG_CORNER_B_Z:       corner_b_z       <= cfg.data[CW-1:0];
        REG_FEATHER_FRACTION: feather_fraction <= cfg.data[FW-1:0];
        default: ;
      endcase
    end
  end

  // Credit covers every transaction taken in and not yet popped by the back end.
  assign point.ready = (credit < CNT_W'(QUEUE_DEPTH));
  assign accept      = point.valid && point.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else if (accept && !pop) begin
      credit <= credit + 1'b1;
    end else if (!accept && pop) begin
      credit <= credit - 1'b1;
    end
  end

  assign a_lt_b_x = corner_a_x < corner_b_x;
  assign a_lt_b_z = corner_a_z < corner_b_z;
  assign frac_sat = (feather_fraction > FULL) ? FULL : feather_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_px   <= point.point_x;
    s1_pz   <= point.point_z;
    s1_x_lo <= a_lt_b_x ? corner_a_x : corner_b_x;
    s1_x_hi <= a_lt_b_x ? corner_b_x : corner_a_x;
    s1_z_lo <= a_lt_b_z ? corner_a_z : corner_b_z;
    s1_z_hi <= a_lt_b_z ? corner_b_z : corner_a_z;
    s1_frac <= frac_sat;

    s2_inside <= !(s1_px < s1_x_lo || s1_px > s1_x_hi || s1_pz < s1_z_lo || s1_pz > s1_z_hi);
    s2_d0     <= {s1_px[CW-1], s1_px} - {s1_x_lo[CW-1], s1_x_lo};
    s2_d1     <= {s1_x_hi[CW-1], s1_x_hi} - {s1_px[CW-1], s1_px};
    s2_d2     <= {s1_pz[CW-1], s1_pz} - {s1_z_lo[CW-1], s1_z_lo};
    s2_d3     <= {s1_z_hi[CW-1], s1_z_hi} - {s1_pz[CW-1], s1_pz};
    s2_sx     <= {s1_x_hi[CW-1], s1_x_hi} - {s1_x_lo[CW-1], s1_x_lo};
    s2_sz     <= {s1_z_hi[CW-1], s1_z_hi} - {s1_z_lo[CW-1], s1_z_lo};
    s2_frac   <= s1_frac;

    s3_inside <= s2_inside;
    s3_side   <= (s2_sx < s2_sz) ? s2_sx : s2_sz;
    s3_m01    <= (s2_d1 < s2_d0) ? s2_d1 : s2_d0;
    s3_m23    <= (s2_d3 < s2_d2) ? s2_d3 : s2_d2;
    s3_frac   <= s2_frac;

    s4_inside <= s3_inside;
    s4_prod   <= {{FW{1'b0}}, s3_side} * {{DW{1'b0}}, s3_frac};
    s4_mind   <= (s3_m23 < s3_m01) ? s3_m23 : s3_m01;
  end

  // The feather length is at most half the shorter side, so it fits the coordinate width,
  // as does any distance below it.
  assign feather            = s4_prod[PW-1:FW];
  assign push               = s4_valid;
  assign push_flags.in_rect = s4_inside;
  assign push_flags.full    = (feather == '0) || (s4_mind >= feather);
  assign push_mind          = s4_mind[CW-1:0];
  assign push_feather       = feather[CW-1:0];

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CNT_W'(QUEUE_DEPTH))
    else $error("front: credit count above queue depth");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    (credit == '0) |-> !push)
    else $error("front: queue write with no transaction outstanding");
`endif

endmodule

// ===== sv/rbfw_queue.sv =====
// Short queue that decouples the classification pipeline from the divider.
module rbfw_queue import rbfw_pkg::*; #(
  parameter int COORD_WIDTH = RBFW_COORD_WIDTH,
  parameter int QUEUE_DEPTH = RBFW_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rbfw_flags_t             push_flags,
  input  logic [COORD_WIDTH-1:0]  push_mind,
  input  logic [COORD_WIDTH-1:0]  push_feather,
  input  logic                    pop,
  output logic                    empty,
  output rbfw_flags_t             rd_flags,
  output logic [COORD_WIDTH-1:0]  rd_mind,
  output logic [COORD_WIDTH-1:0]  rd_feather
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rbfw_flags_t              flags_q   [QUEUE_DEPTH];
  logic [COORD_WIDTH-1:0]   mind_q    [QUEUE_DEPTH];
  logic [COORD_WIDTH-1:0]   feather_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr, rd_ptr;
  logic [CNT_W-1:0]         count;

  assign empty      = (count == '0);
  assign rd_flags   = flags_q[rd_ptr];
  assign rd_mind    = mind_q[rd_ptr];
  assign rd_feather = feather_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      flags_q[wr_ptr]   <= push_flags;
      mind_q[wr_ptr]    <= push_mind;
      feather_q[wr_ptr] <= push_feather;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue: write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue: read while empty");
`endif

endmodule

// ===== sv/rbfw_back.sv =====
// Back end: pipelined restoring divider, one quotient bit a stage, and the result register.
module rbfw_back import rbfw_pkg::*; #(
  parameter int COORD_WIDTH      = RBFW_COORD_WIDTH,
  parameter int WEIGHT_FRAC_BITS = RBFW_WEIGHT_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  input  rbfw_flags_t             rd_flags,
  input  logic [COORD_WIDTH-1:0]  rd_mind,
  input  logic [COORD_WIDTH-1:0]  rd_feather,
  output logic                    pop,
  rbfw_result_if.source           result
);

  localparam int CW  = COORD_WIDTH;
  localparam int QW  = WEIGHT_FRAC_BITS;
  localparam int FW  = QW + 1;
  localparam int NST = QW + 1;
  localparam logic [FW-1:0] FULL = FW'(1 << QW);

  logic              en;
  logic              st_valid   [NST];
  rbfw_flags_t       st_flags   [NST];
  logic [CW-1:0]     st_r       [NST];
  logic [CW-1:0]     st_feather [NST];
  logic [QW-1:0]     st_q       [NST];
  logic [CW:0]       step_r2    [NST];
  logic              step_ge    [NST];
  logic              out_valid;
  logic [FW-1:0]     out_weight;
  logic              out_inside;

  // The whole back end moves together whenever the result register can take a new value.
  assign en  = !out_valid || result.ready;
  assign pop = en && !empty;

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      step_r2[k] = {st_r[k], 1'b0};
      step_ge[k] = step_r2[k] >= {1'b0, st_feather[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) begin
        st_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      st_valid[0] <= pop;
      for (int k = 1; k < NST; k++) begin
        st_valid[k] <= st_valid[k-1];
      end
      out_valid <= st_valid[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_flags[0]   <= rd_flags;
      st_r[0]       <= rd_mind;
      st_feather[0] <= rd_feather;
      st_q[0]       <= '0;
      for (int k = 1; k < NST; k++) begin
        st_flags[k]   <= st_flags[k-1];
        st_feather[k] <= st_feather[k-1];
        st_r[k]       <= step_ge[k-1] ? CW'(step_r2[k-1] - {1'b0, st_feather[k-1]})
                                      : step_r2[k-1][CW-1:0];
        st_q[k]       <= {st_q[k-1][QW-2:0], step_ge[k-1]};
      end
      out_inside <= st_flags[NST-1].in_rect;
      if (!st_flags[NST-1].in_rect) begin
        out_weight <= '0;
      end else if (st_flags[NST-1].full) begin
        out_weight <= FULL;
      end else begin
        out_weight <= {1'b0, st_q[NST-1]};
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.weight     = out_weight;
  assign result.inside_res = out_inside;

`ifndef SYNTHESIS
  a_divider_range: assert property (@(posedge clk) disable iff (rst)
    st_valid[0] && st_flags[0].in_rect && !st_flags[0].full |-> st_r[0] < st_feather[0])
    else $error("back: dividend not below feather length");

  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.weight <= FULL)
    else $error("back: weight above full scale");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.inside_res |-> result.weight == '0)
    else $error("back: outside point with non-zero weight");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rectangle boundary feather weight block.
module tb_top;
  import rbfw_pkg::*;

  localparam int WFB = RBFW_WEIGHT_FRAC_BITS;
  localparam int CW = RBFW_COORD_WIDTH;
  localparam int LATENCY = WFB + 7;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_POINTS = 115;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [WFB:0] weight_t;
  typedef struct {
    coord_t x;
    coord_t z;
  } point_t;
  typedef struct {
    coord_t  x;
    coord_t  z;
    weight_t weight;
    logic    in_rect;
  } weight_res_t;
  typedef struct {
    longint x_lo, x_hi, z_lo, z_hi, feather;
  } rect_t;

  logic clk = 1'b0;
  logic rst;

  rbfw_point_if  pt_if ();
  rbfw_result_if res_if ();
  rbfw_cfg_if    cfg_if ();

  rect_boundary_feather_weight_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .point  (pt_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // Register contents as the block should hold them.
  coord_t  corner_ax = '0;
  coord_t  corner_az = '0;
  coord_t  corner_bx = '0;
  coord_t  corner_bz = '0;
  weight_t feather_frac = '0;

  point_t      pending_points[$];
  weight_res_t expected_weights[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;
  int points_sent = 0;
  int settings_used = 0;
  int stuck_cycles = 0;

  always #4 clk = ~clk;

  function automatic rect_t rect_geometry();
    rect_t  g;
    longint ax, az, bx, bz, side, frac;
    ax = corner_ax;
    az = corner_az;
    bx = corner_bx;
    bz = corner_bz;
    g.x_lo = (ax < bx) ? ax : bx;
    g.x_hi = (ax < bx) ? bx : ax;
    g.z_lo = (az < bz) ? az : bz;
    g.z_hi = (az < bz) ? bz : az;
    side = (g.x_hi - g.x_lo < g.z_hi - g.z_lo) ? g.x_hi - g.x_lo : g.z_hi - g.z_lo;
    // A fraction above one is taken as exactly one.
    frac = (feather_frac > (1 << WFB)) ? (longint'(1) << WFB) : longint'(feather_frac);
    g.feather = (side * frac) >> (WFB + 1);
    return g;
  endfunction

  function automatic weight_res_t feather_weight(coord_t px, coord_t pz);
    rect_t       g;
    weight_res_t r;
    longint      x, z, mind;
    g = rect_geometry();
    x = px;
    z = pz;
    r.x = px;
    r.z = pz;
    r.weight = '0;
    r.in_rect = 1'b0;
    if (x >= g.x_lo && x <= g.x_hi && z >= g.z_lo && z <= g.z_hi) begin
      r.in_rect = 1'b1;
      mind = x - g.x_lo;
      if (g.x_hi - x < mind) mind = g.x_hi - x;
      if (z - g.z_lo < mind) mind = z - g.z_lo;
      if (g.z_hi - z < mind) mind = g.z_hi - z;
      if (g.feather == 0 || mind >= g.feather) begin
        r.weight = weight_t'(1 << WFB);
      end else begin
        r.weight = weight_t'((mind << WFB) / g.feather);
      end
    end
    return r;
  endfunction

  function automatic coord_t sat_coord(longint v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic longint coord_between(longint lo, longint hi);
    longint unsigned span, r;
    span = longint'(hi - lo + 1);
    r = {$urandom, $urandom};
    return lo + longint'(r % span);
  endfunction

  task automatic push_at(longint x, longint z);
    point_t p;
    p.x = sat_coord(x);
    p.z = sat_coord(z);
    pending_points.push_back(p);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_points.size() != 0 || pt_if.valid || expected_weights.size() != 0);
  endtask

  task automatic write_reg(logic [RBFW_CFG_INDEX_W-1:0] idx, logic [RBFW_CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_CORNER_A_X:       corner_ax = value;
      REG_CORNER_A_Z:       corner_az = value;
      REG_CORNER_B_X:       corner_bx = value;
      REG_CORNER_B_Z:       corner_bz = value;
      REG_FEATHER_FRACTION: feather_frac = value[WFB:0];
      default: ;
    endcase
  endtask

  task automatic set_rect(coord_t ax, coord_t az, coord_t bx, coord_t bz, weight_t frac);
    write_reg(REG_CORNER_A_X, ax);
    write_reg(REG_CORNER_A_Z, az);
    write_reg(REG_CORNER_B_X, bx);
    write_reg(REG_CORNER_B_Z, bz);
    write_reg(REG_FEATHER_FRACTION, RBFW_CFG_DATA_W'(frac));
    settings_used++;
  endtask

  // Centre anywhere from near the origin to the far range, half sizes from zero upwards.
  task automatic random_rect(weight_t frac);
    longint cx, cz, hx, hz;
    coord_t ax, az, bx, bz;
    cx = coord_t'($urandom) >>> $urandom_range(0, 16);
    cz = coord_t'($urandom) >>> $urandom_range(0, 16);
    hx = $urandom >> $urandom_range(1, 31);
    hz = $urandom >> $urandom_range(1, 31);
    ax = sat_coord(cx - hx);
    bx = sat_coord(cx + hx);
    az = sat_coord(cz - hz);
    bz = sat_coord(cz + hz);
    if ($urandom_range(1)) set_rect(bx, az, ax, bz, frac);
    else set_rect(ax, bz, bx, az, frac);
  endtask

  task automatic directed_points();
    rect_t  g;
    longint mx, mz, f;
    g = rect_geometry();
    mx = (g.x_lo + g.x_hi) / 2;
    mz = (g.z_lo + g.z_hi) / 2;
    f = g.feather;
    push_at(mx, mz);
    push_at(g.x_lo, mz);
    push_at(g.x_hi, mz);
    push_at(mx, g.z_lo);
    push_at(mx, g.z_hi);
    push_at(g.x_lo, g.z_lo);
    push_at(g.x_hi, g.z_hi);
    push_at(g.x_lo, g.z_hi);
    push_at(g.x_lo - 1, mz);
    push_at(g.x_hi + 1, mz);
    push_at(mx, g.z_lo - 1);
    push_at(mx, g.z_hi + 1);
    // Around the feather distance: exactly at it the ratio comes out as full weight.
    push_at(g.x_lo + f, mz);
    push_at(g.x_lo + f - 1, mz);
    push_at(g.x_lo + f + 1, mz);
    push_at(g.x_lo + 1, mz);
    push_at(mx, g.z_hi - f);
    push_at(COORD_MIN, COORD_MIN);
    push_at(COORD_MAX, COORD_MAX);
    push_at(COORD_MIN, COORD_MAX);
    push_at(COORD_MAX, COORD_MIN);
  endtask

  task automatic push_random_point();
    rect_t  g;
    longint x, z, d;
    int     pick;
    g = rect_geometry();
    pick = $urandom_range(99);
    x = coord_between(g.x_lo, g.x_hi);
    z = coord_between(g.z_lo, g.z_hi);
    if (pick < 35) begin
      // uniform over the rectangle
    end else if (pick < 60) begin
      d = coord_between(0, g.feather + 2);
      case ($urandom_range(3))
        0:       x = g.x_lo + d;
        1:       x = g.x_hi - d;
        2:       z = g.z_lo + d;
        default: z = g.z_hi - d;
      endcase
    end else if (pick < 78) begin
      if ($urandom_range(2) != 0)
        x = ($urandom_range(1) ? g.x_lo : g.x_hi) + int'($urandom_range(2)) - 1;
      if ($urandom_range(2) != 0)
        z = ($urandom_range(1) ? g.z_lo : g.z_hi) + int'($urandom_range(2)) - 1;
    end else begin
      x = coord_t'($urandom);
      z = coord_t'($urandom);
    end
    push_at(x, z);
  endtask

  task automatic run_phase(int mode, int count, bit pause_midway);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
    for (int i = 0; i < count; i++) begin
      push_random_point();
      // Hold the sender back until the pipeline has emptied completely.
      if (pause_midway && i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk) begin : point_driver
    point_t next_point;
    if (rst) begin
      pt_if.valid <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        expected_weights.push_back(feather_weight(pt_if.point_x, pt_if.point_z));
        points_sent++;
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_point = pending_points.pop_front();
          pt_if.valid   <= 1'b1;
          pt_if.point_x <= next_point.x;
          pt_if.point_z <= next_point.z;
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    weight_res_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_weights.size() == 0) begin
          mismatches++;
          $display("%0t: result with no point outstanding: weight %0d inside %0b",
                   $time, res_if.weight, res_if.inside_res);
        end else begin
          want = expected_weights.pop_front();
          results_checked++;
          if (res_if.weight !== want.weight || res_if.inside_res !== want.in_rect) begin
            mismatches++;
            $display("%0t: point (%0d, %0d) expected weight %0d inside %0b, got %0d %0b",
                     $time, want.x, want.z, want.weight, want.in_rect,
                     res_if.weight, res_if.inside_res);
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_weights.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    weight_t frac;
    rst = 1'b1;
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_z = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the rectangle is a single point at the origin with no feather.
    push_at(0, 0);
    push_at(1, 0);
    push_at(0, -1);
    push_at(COORD_MIN, COORD_MAX);
    push_at(-1, -1);
    wait_drained();

    // Corners given high-then-low on both axes, half feather.
    set_rect(coord_t'(655360), coord_t'(1310720), coord_t'(-327680), coord_t'(131072),
             weight_t'(17'h08000));
    directed_points();
    wait_drained();

    set_rect(coord_t'(COORD_MIN), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
             coord_t'(COORD_MIN), weight_t'(1 << WFB));
    directed_points();
    run_phase(0, PHASE_POINTS, 1'b0);

    set_rect(coord_t'(-196608), coord_t'(65536), coord_t'(278528), coord_t'(-491520), '0);
    directed_points();
    run_phase(1, PHASE_POINTS, 1'b0);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          // Zero width on x: every inside point lies on an edge.
          frac = $urandom_range(0, 1 << WFB);
          set_rect(coord_t'(-8192), coord_t'($urandom), coord_t'(-8192),
                   coord_t'($urandom), frac);
        end
        1:       random_rect('0);
        2:       random_rect('1);
        3:       random_rect(weight_t'((1 << WFB) + $urandom_range(1, (1 << WFB) - 1)));
        4:       random_rect(weight_t'(1));
        default: random_rect(weight_t'($urandom_range(0, 1 << WFB)));
      endcase
      run_phase(p % 4, PHASE_POINTS, p == 5);
    end

    repeat (LATENCY + 8) @(posedge clk);
    $display("Run covered %0d points over %0d register settings: unordered, full-range,",
             points_sent, settings_used);
    $display("zero-width, zero and saturated feather rectangles; %0d results compared.",
             results_checked);
    if (mismatches == 0 && expected_weights.size() == 0 && pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, expected_weights.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== rect_boundary_feather_weight_top.f =====
sv/rbfw_pkg.sv
sv/rbfw_if.sv
sv/rbfw_front.sv
sv/rbfw_queue.sv
sv/rbfw_back.sv
sv/rect_boundary_feather_weight_top.sv
tb/tb_top.sv
